// ----- rtl/pcm_pkg.sv -----
// ----------------------------------------------------------------------------
// pcm_pkg: shared types and constants of the perspective coordinate map
// Coefficient format, register indexes and the per-item side-band record.
// ----------------------------------------------------------------------------
package pcm_pkg;

	// coefficient format, signed Q16.32
	localparam int COEF_W    = 48;
	localparam int COEF_FRAC = 32;
	localparam int COEF_HALF = COEF_W / 2;
	localparam int NUM_COEF  = 8;
	localparam int IDX_W     = $clog2(NUM_COEF);

	// result format and quotient length
	localparam int OUT_W = 32;
	localparam int QBITS = OUT_W;

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_XX = 3'd0,
		REG_XY = 3'd1,
		REG_XT = 3'd2,
		REG_YX = 3'd3,
		REG_YY = 3'd4,
		REG_YT = 3'd5,
		REG_PX = 3'd6,
		REG_PY = 3'd7
	} reg_idx_t;

	// side-band flags that travel with an item through the divider
	typedef struct packed {
		logic sel;
		logic zero;
		logic negx;
		logic negy;
		logic ovfx;
		logic ovfy;
	} meta_t;

endpackage

// ----- rtl/pcm_if.sv -----
// ----------------------------------------------------------------------------
// pcm_in_if / pcm_out_if: item channels of the perspective coordinate map
// Valid/ready channels carrying destination pixels in and source coordinates out.
// ----------------------------------------------------------------------------
interface pcm_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] dst_x;
	logic signed [COORD_BITS-1:0] dst_y;
	logic                         selected;

	modport source (output valid, dst_x, dst_y, selected, input ready);
	modport sink   (input valid, dst_x, dst_y, selected, output ready);
endinterface

interface pcm_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] src_x;
	logic signed [31:0] src_y;
	logic               mapped;
	logic               zero_denominator;
	logic               saturated;

	modport source (output valid, src_x, src_y, mapped, zero_denominator, saturated,
		input ready);
	modport sink   (input valid, src_x, src_y, mapped, zero_denominator, saturated,
		output ready);
endinterface

// ----- rtl/perspective_coordinate_map.sv -----
// ----------------------------------------------------------------------------
// perspective_coordinate_map: homography destination-to-source pixel mapping
// Pipelined multiply, sum, and two restoring dividers for Q16.16 coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in  carries destination pixels (dst_x, dst_y, selected); pix_out carries
//   one result per item (src_x, src_y, mapped, zero_denominator, saturated).
//   The eight Q16.32 coefficients are written through cfg_we/cfg_idx/cfg_data
//   while the pipeline is empty; reset loads the identity mapping.
// Throughput: one item per cycle, back to back, while pix_out does not stall.
// Pipeline: two multiply/sum stages, one sign/magnitude stage and one
//   range-check stage precede the divider, whose length is one stage per
//   quotient bit (32).
// Stall: the whole pipeline holds while a result waits at pix_out; pix_in.ready
//   then drops, so nothing is lost or repeated.
// Reset: arst_n clears all valid bits and the coefficients to their defaults;
//   payload registers are not reset.
// ----------------------------------------------------------------------------
module perspective_coordinate_map
	import pcm_pkg::*;
#(
	parameter int COORD_BITS    = 16,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_idx,
	input  logic [COEF_W-1:0] cfg_data,
	pcm_in_if.sink            pix_in,
	pcm_out_if.source         pix_out
);

	localparam int CW  = COORD_BITS;
	localparam int LW  = CW + COEF_HALF + 1;
	localparam int HW  = CW + COEF_HALF;
	localparam int SW  = CW + COEF_W + 1;
	localparam int RW  = SW + QBITS;
	localparam logic signed [SW-1:0] DEN_ONE = SW'(1) <<< COEF_FRAC;
	localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic [OUT_W-1:0] NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

	// coefficient registers
	logic signed [COEF_W-1:0] coef_q [NUM_COEF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= '0;
			coef_q[REG_XX] <= COEF_W'(1) << COEF_FRAC;
			coef_q[REG_YY] <= COEF_W'(1) << COEF_FRAC;
		end else if (cfg_we) begin
			coef_q[cfg_idx] <= cfg_data;
		end
	end

	// global advance: move when the output register is free or being taken
	logic out_vld_q;
	logic adv;
	assign adv          = !out_vld_q || pix_out.ready;
	assign pix_in.ready = adv;

	// stage 1: split each product into two narrow partial products
	localparam int NP = 6;
	logic signed [LW-1:0] plo_s1 [NP];
	logic signed [HW-1:0] phi_s1 [NP];
	logic                 vld_s1, sel_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= pix_in.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s1 <= pix_in.selected;
			for (int k = 0; k < NP; k++) begin
				logic [IDX_W-1:0] ci;
				logic             use_y;
				ci    = (k == 0) ? REG_XX : (k == 1) ? REG_XY : (k == 2) ? REG_YX :
					(k == 3) ? REG_YY : (k == 4) ? REG_PX : REG_PY;
				use_y = (k % 2) == 1;
				plo_s1[k] <= LW'((use_y ? pix_in.dst_y : pix_in.dst_x) *
					$signed({1'b0, coef_q[ci][COEF_HALF-1:0]}));
				phi_s1[k] <= HW'((use_y ? pix_in.dst_y : pix_in.dst_x) *
					$signed(coef_q[ci][COEF_W-1:COEF_HALF]));
			end
		end
	end

	// stage 2: recombine partial products and form the three sums
	logic signed [SW-1:0] prod [NP];
	always_comb begin
		for (int k = 0; k < NP; k++)
			prod[k] = (SW'(phi_s1[k]) <<< COEF_HALF) + SW'(plo_s1[k]);
	end

	logic signed [SW-1:0] nx_s2, ny_s2, den_s2;
	logic                 vld_s2, sel_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s2 <= sel_s1;
			nx_s2  <= prod[0] + prod[1] + SW'(coef_q[REG_XT]);
			ny_s2  <= prod[2] + prod[3] + SW'(coef_q[REG_YT]);
			den_s2 <= prod[4] + prod[5] + DEN_ONE;
		end
	end

	// stage 3: replace a zero denominator, take magnitudes and signs
	logic            den_zero;
	logic [SW-1:0]   den_fix, nxm, nym, dm;
	always_comb begin
		den_zero = den_s2 == '0;
		den_fix  = den_zero ? DEN_ONE : den_s2;
		nxm      = nx_s2[SW-1] ? SW'(-nx_s2) : nx_s2;
		nym      = ny_s2[SW-1] ? SW'(-ny_s2) : ny_s2;
		dm       = den_fix[SW-1] ? SW'(-den_fix) : den_fix;
	end

	logic [RW-1:0] nx_s3, ny_s3;
	logic [SW-1:0] dm_s3;
	logic          vld_s3, sel_s3, zero_s3, negx_s3, negy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s3  <= sel_s2;
			zero_s3 <= den_zero;
			negx_s3 <= nx_s2[SW-1] ^ den_fix[SW-1];
			negy_s3 <= ny_s2[SW-1] ^ den_fix[SW-1];
			nx_s3   <= RW'(nxm) << OUT_FRAC_BITS;
			ny_s3   <= RW'(nym) << OUT_FRAC_BITS;
			dm_s3   <= dm;
		end
	end

	// stage 4: flag quotients of 2^32 or more, which saturate outright
	logic [RW-1:0] dtop;
	assign dtop = RW'(dm_s3) << QBITS;

	logic [RW-1:0]    rx_d [QBITS+1];
	logic [RW-1:0]    ry_d [QBITS+1];
	logic [QBITS-1:0] qx_d [QBITS+1];
	logic [QBITS-1:0] qy_d [QBITS+1];
	logic [SW-1:0]    dm_d [QBITS+1];
	meta_t            meta_d [QBITS+1];
	logic             vld_d [QBITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_d[0] <= 1'b0;
		else if (adv) vld_d[0] <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rx_d[0]        <= nx_s3;
			ry_d[0]        <= ny_s3;
			qx_d[0]        <= '0;
			qy_d[0]        <= '0;
			dm_d[0]        <= dm_s3;
			meta_d[0].sel  <= sel_s3;
			meta_d[0].zero <= zero_s3;
			meta_d[0].negx <= negx_s3;
			meta_d[0].negy <= negy_s3;
			meta_d[0].ovfx <= nx_s3 >= dtop;
			meta_d[0].ovfy <= ny_s3 >= dtop;
		end
	end

	// divider: one restoring step per stage, most significant quotient bit first
	for (genvar i = 0; i < QBITS; i++) begin : g_div
		localparam int B = QBITS - 1 - i;
		logic [RW-1:0] dsh;
		logic          gex, gey;
		assign dsh = RW'(dm_d[i]) << B;
		assign gex = rx_d[i] >= dsh;
		assign gey = ry_d[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[i+1] <= 1'b0;
			else if (adv) vld_d[i+1] <= vld_d[i];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_d[i+1]   <= gex ? rx_d[i] - dsh : rx_d[i];
				ry_d[i+1]   <= gey ? ry_d[i] - dsh : ry_d[i];
				qx_d[i+1]   <= qx_d[i] | (QBITS'(gex) << B);
				qy_d[i+1]   <= qy_d[i] | (QBITS'(gey) << B);
				dm_d[i+1]   <= dm_d[i];
				meta_d[i+1] <= meta_d[i];
			end
		end
	end

	// output stage: apply sign, clamp to range, blank unselected pixels
	function automatic logic [OUT_W:0] fix_sign(logic [QBITS-1:0] q, logic neg, logic ovf);
		logic [OUT_W:0] r;
		if (neg) begin
			if (ovf || q > NEG_MAX) r = {1'b1, NEG_MAX};
			else                    r = {1'b0, OUT_W'(-q)};
		end else begin
			if (ovf || q > POS_MAX) r = {1'b1, POS_MAX};
			else                    r = {1'b0, q};
		end
		return r;
	endfunction

	logic [OUT_W:0] fx, fy;
	meta_t          mt;
	assign mt = meta_d[QBITS];
	assign fx = fix_sign(qx_d[QBITS], mt.negx, mt.ovfx);
	assign fy = fix_sign(qy_d[QBITS], mt.negy, mt.ovfy);

	logic [OUT_W-1:0] sx_q, sy_q;
	logic             map_q, zero_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= vld_d[QBITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_q   <= mt.sel ? fx[OUT_W-1:0] : '0;
			sy_q   <= mt.sel ? fy[OUT_W-1:0] : '0;
			map_q  <= mt.sel;
			zero_q <= mt.sel & mt.zero;
			sat_q  <= mt.sel & (fx[OUT_W] | fy[OUT_W]);
		end
	end

	assign pix_out.valid            = out_vld_q;
	assign pix_out.src_x            = sx_q;
	assign pix_out.src_y            = sy_q;
	assign pix_out.mapped           = map_q;
	assign pix_out.zero_denominator = zero_q;
	assign pix_out.saturated        = sat_q;

endmodule
